>>> rtl/tw_pkg.sv
// ----------------------------------------------------------------------------
// tw_pkg
// Shared types and constants for the two-wire display serial transmitter.
// ----------------------------------------------------------------------------
package tw_pkg;

   localparam int QTICK_W = 16;
   localparam logic [QTICK_W-1:0] QTICK_RESET = 16'd128;

   // line drive bit positions
   localparam int SCL_BIT = 0;
   localparam int SDA_BIT = 1;
   localparam logic [1:0] LINES_HIGH = 2'b11;

   typedef enum logic [2:0] {
      PH_IDLE  = 3'd0,
      PH_START = 3'd1,
      PH_DATA  = 3'd2,
      PH_ACK   = 3'd3,
      PH_STOP  = 3'd4,
      PH_WAIT  = 3'd5
   } phase_type;

   typedef enum logic {
      OP_TICK = 1'b0,
      OP_BYTE = 1'b1
   } op_type;

   typedef struct packed {
      logic       func;
      logic [7:0] byte_data;
      logic       first_of_frame;
      logic       last_of_frame;
      logic       sda_sample;
   } req_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_level;
      logic       ready_res;
      logic       ack_missing;
      logic [7:0] nack_count;
      logic       frame_done;
   } rsp_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] byte_data;
      logic       first_of_frame;
      logic       last_of_frame;
      logic       sda_sample;
   } cmd_type;

endpackage

>>> rtl/two_wire_display_serial_tx_top.sv
// ----------------------------------------------------------------------------
// two_wire_display_serial_tx_top
// Two-wire LSB-first display transmitter: request queue, line engine and
// response queue.
// ----------------------------------------------------------------------------
//  port group   direction  handshake          payload
//  req_         in         req_push/req_full  req_data (func, byte, framing, sda)
//  rsp_         out        rsp_empty/rsp_pop  rsp_data (lines, ready, ack status)
//  csr_         in         csr_we             csr_wdata (quarter_ticks)
//
//  With rsp_pop held high, one beat per cycle is sustained in both
//  directions; the line engine handles one command per cycle while the
//  response queue is not full. A beat is registered in the command queue,
//  then in the response queue after the engine, before it shows on rsp_.
//  Reset: lines released high, engine idle, quarter_ticks = 128, queues empty.
//  With rsp_pop low the response queue fills, then the command queue, then
//  req_full rises; nothing is dropped.
// ----------------------------------------------------------------------------
module two_wire_display_serial_tx_top #(
   parameter int CMD_DEPTH = 2,
   parameter int RSP_DEPTH = 2
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_push,
   input  tw_pkg::req_type            req_data,
   output logic                       req_full,
   output logic                       rsp_empty,
   input  logic                       rsp_pop,
   output tw_pkg::rsp_type            rsp_data,
   input  logic                       csr_we,
   input  logic [tw_pkg::QTICK_W-1:0] csr_wdata
);
   import tw_pkg::*;

   cmd_type cmd;
   logic    cmd_valid;
   logic    cmd_pop;
   rsp_type rsp_next;
   logic    rsp_push;
   logic    rsp_full;

   tw_front #(
      .DEPTH (CMD_DEPTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .cmd_pop   (cmd_pop),
      .cmd       (cmd),
      .cmd_valid (cmd_valid)
   );

   tw_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp       (rsp_next)
   );

   tw_queue #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_next),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_data),
      .empty     (rsp_empty)
   );

endmodule

>>> rtl/tw_queue.sv
// ----------------------------------------------------------------------------
// tw_queue
// Small register queue with a count; push and pop in the same cycle allowed.
// ----------------------------------------------------------------------------
module tw_queue #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [AW-1:0]    wr_ff, wr_in;
   logic [AW-1:0]    rd_ff, rd_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full     = (cnt_ff == CW'(DEPTH));
   assign empty    = (cnt_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == AW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == AW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   cnt_in = cnt_ff + 1'b1;
         2'b01:   cnt_in = cnt_ff - 1'b1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/tw_front.sv
// ----------------------------------------------------------------------------
// tw_front
// Accepts request beats, classifies them as tick or byte offer, and queues
// the resulting commands for the line engine.
// ----------------------------------------------------------------------------
module tw_front #(
   parameter int DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  tw_pkg::req_type   req_data,
   output logic              req_full,
   input  logic              cmd_pop,
   output tw_pkg::cmd_type   cmd,
   output logic              cmd_valid
);
   import tw_pkg::*;

   cmd_type cmd_push;
   logic    cmd_empty;

   always_comb begin
      cmd_push.op             = req_data.func ? OP_BYTE : OP_TICK;
      cmd_push.byte_data      = req_data.byte_data;
      cmd_push.first_of_frame = req_data.first_of_frame;
      cmd_push.last_of_frame  = req_data.last_of_frame;
      cmd_push.sda_sample     = req_data.sda_sample;
   end

   tw_queue #(
      .WIDTH ($bits(cmd_type)),
      .DEPTH (DEPTH)
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (cmd_push),
      .full      (req_full),
      .pop       (cmd_pop),
      .pop_data  (cmd),
      .empty     (cmd_empty)
   );

   assign cmd_valid = !cmd_empty;

endmodule

>>> rtl/tw_back.sv
// ----------------------------------------------------------------------------
// tw_back
// Line engine: quarter-period timer, frame sequencer and ack bookkeeping.
// Takes one command per cycle unless rsp_full, with one response beat each.
// ----------------------------------------------------------------------------
module tw_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [tw_pkg::QTICK_W-1:0] csr_wdata,
   input  logic                       cmd_valid,
   input  tw_pkg::cmd_type            cmd,
   output logic                       cmd_pop,
   input  logic                       rsp_full,
   output logic                       rsp_push,
   output tw_pkg::rsp_type            rsp
);
   import tw_pkg::*;

   phase_type          phase_ff, phase_in;
   logic [2:0]         quarter_ff, quarter_in;
   logic [3:0]         bit_ff, bit_in;
   logic [7:0]         shift_ff, shift_in;
   logic [QTICK_W-1:0] tick_ff, tick_in;
   logic               stop_ff, stop_in;
   logic [7:0]         miss_ff, miss_in;
   logic [1:0]         line_ff, line_in;
   logic               nack_ff, nack_in;
   logic [QTICK_W-1:0] qticks_ff;

   logic               take;
   logic               busy;
   logic               ready;
   logic               done;
   logic [QTICK_W-1:0] tick_next;
   logic [QTICK_W-1:0] limit;

   // line levels at the start of a quarter
   function automatic logic [1:0] quarter_lines(phase_type ph, logic [2:0] q,
                                                logic [3:0] bi, logic [7:0] sh,
                                                logic [1:0] cur);
      logic [1:0] l;
      l = cur;
      case (ph)
         PH_START: l = (q < 3'd4) ? LINES_HIGH : 2'b01;
         PH_DATA: begin
            if (q == 3'd0) l[SCL_BIT] = 1'b0;
            else if (q == 3'd1) l[SDA_BIT] = sh[bi[2:0]];
            else if (q == 3'd2) l[SCL_BIT] = 1'b1;
         end
         PH_ACK: begin
            if (q == 3'd0) l[SCL_BIT] = 1'b0;
            else if (q == 3'd1) l[SDA_BIT] = 1'b1;
            else if (q == 3'd2) l[SCL_BIT] = 1'b1;
         end
         PH_STOP: begin
            if (q == 3'd0) l = 2'b00;
            else if (q == 3'd2) l[SCL_BIT] = 1'b1;
         end
         PH_WAIT: l = cur;
         default: l = LINES_HIGH;
      endcase
      return l;
   endfunction

   assign take      = cmd_valid && !rsp_full;
   assign cmd_pop   = take;
   assign rsp_push  = take;
   assign busy      = (phase_ff == PH_START) || (phase_ff == PH_DATA) ||
                      (phase_ff == PH_ACK) || (phase_ff == PH_STOP);
   assign tick_next = tick_ff + 1'b1;
   assign limit     = (qticks_ff == '0) ? QTICK_W'(1) : qticks_ff;

   always_comb begin
      phase_in   = phase_ff;
      quarter_in = quarter_ff;
      bit_in     = bit_ff;
      shift_in   = shift_ff;
      tick_in    = tick_ff;
      stop_in    = stop_ff;
      miss_in    = miss_ff;
      line_in    = line_ff;
      nack_in    = nack_ff;
      ready      = 1'b0;
      done       = 1'b0;
      if (take) begin
         if (cmd.op == OP_BYTE) begin
            if ((phase_ff == PH_IDLE && cmd.first_of_frame) || phase_ff == PH_WAIT) begin
               if (phase_ff == PH_WAIT) begin
                  phase_in = PH_DATA;
               end else begin
                  phase_in = PH_START;
                  miss_in  = '0;
               end
               quarter_in = '0;
               bit_in     = '0;
               tick_in    = '0;
               shift_in   = cmd.byte_data;
               stop_in    = cmd.last_of_frame;
               line_in    = quarter_lines(phase_in, 3'd0, 4'd0, cmd.byte_data, line_ff);
               ready      = 1'b1;
            end
         end else if (busy) begin
            tick_in = tick_next;
            if (tick_next >= limit || tick_next == '0) begin
               tick_in = '0;
               // quarter ended: advance the sequence
               case (phase_ff)
                  PH_START: begin
                     if (quarter_ff >= 3'd5) begin
                        phase_in   = PH_DATA;
                        bit_in     = '0;
                        quarter_in = '0;
                     end else begin
                        quarter_in = quarter_ff + 1'b1;
                     end
                  end
                  PH_DATA: begin
                     if (quarter_ff >= 3'd3) begin
                        bit_in     = bit_ff + 1'b1;
                        quarter_in = '0;
                        if (bit_in >= 4'd8) phase_in = PH_ACK;
                     end else begin
                        quarter_in = quarter_ff + 1'b1;
                     end
                  end
                  PH_ACK: begin
                     if (quarter_ff == 3'd2) begin
                        nack_in = cmd.sda_sample;
                        if (cmd.sda_sample && miss_ff != 8'hFF) miss_in = miss_ff + 1'b1;
                     end
                     if (quarter_ff >= 3'd3) begin
                        quarter_in = '0;
                        phase_in   = stop_ff ? PH_STOP : PH_WAIT;
                     end else begin
                        quarter_in = quarter_ff + 1'b1;
                     end
                  end
                  PH_STOP: begin
                     if (quarter_ff >= 3'd3) begin
                        quarter_in = '0;
                        phase_in   = PH_IDLE;
                        done       = 1'b1;
                     end else begin
                        quarter_in = quarter_ff + 1'b1;
                     end
                  end
                  default: ;
               endcase
               line_in = quarter_lines(phase_in, quarter_in, bit_in, shift_ff, line_ff);
            end
         end
      end
   end

   always_comb begin
      rsp.scl_level   = line_in[SCL_BIT];
      rsp.sda_level   = line_in[SDA_BIT];
      rsp.ready_res   = ready;
      rsp.ack_missing = nack_in;
      rsp.nack_count  = miss_in;
      rsp.frame_done  = done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         quarter_ff <= '0;
         bit_ff     <= '0;
         shift_ff   <= '0;
         tick_ff    <= '0;
         stop_ff    <= 1'b0;
         miss_ff    <= '0;
         line_ff    <= LINES_HIGH;
         nack_ff    <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         quarter_ff <= quarter_in;
         bit_ff     <= bit_in;
         shift_ff   <= shift_in;
         tick_ff    <= tick_in;
         stop_ff    <= stop_in;
         miss_ff    <= miss_in;
         line_ff    <= line_in;
         nack_ff    <= nack_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         qticks_ff <= QTICK_RESET;
      end else if (csr_we) begin
         qticks_ff <= csr_wdata;
      end
   end

`ifndef NO_ASSERTIONS
   a_done_from_stop: assert property (@(posedge clock) disable iff (reset)
      rsp_push && rsp.frame_done |-> phase_ff == PH_STOP)
      else $error("frame_done outside stop phase");

   a_ready_on_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_push && rsp.ready_res |-> cmd.op == OP_BYTE && phase_in != PH_IDLE)
      else $error("ready_res without an accepted byte");

   a_idle_quarter: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_IDLE |-> quarter_ff == '0 && line_ff == LINES_HIGH)
      else $error("idle with quarter or lines not at rest");

   a_ack_bits: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_ACK |-> bit_ff == 4'd8)
      else $error("ack slot entered before eight bits");

   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !take |=> $stable(phase_ff) && $stable(tick_ff) && $stable(miss_ff))
      else $error("engine state moved without a command");
`endif

endmodule
